>>> rtl/nearest_neighbor_pixel_downscaler_core_defines.svh
// assertion macros shared by the downscaler checker
// no dependencies; every macro expects clk and arst_n in scope
`ifndef NEAREST_NEIGHBOR_PIXEL_DOWNSCALER_CORE_DEFINES_SVH
`define NEAREST_NEIGHBOR_PIXEL_DOWNSCALER_CORE_DEFINES_SVH

// a stalled transfer keeps valid high and its payload unchanged
`define NNDS_ASSERT_STALL_HOLD(label, vld, rdy, data) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(vld && !rdy) |=> (vld && $stable(data))) \
		else $error("stalled transfer changed");

// condition in one cycle forces a condition in the next
`define NNDS_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond) |=> (expr)) \
		else $error("next-cycle rule broken");

// condition forces a condition in the same cycle
`define NNDS_ASSERT_NOW(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond) |-> (expr)) \
		else $error("same-cycle rule broken");

`endif

>>> rtl/nnds_pkg.sv
// shared types and constants of the nearest neighbor downscaler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nnds_pkg;

	localparam int PIX_W         = 8;
	localparam int SRC_SIDE_W    = 13;
	localparam int OUT_WIDTH_W   = 10;
	localparam int OUT_HEIGHT_W  = 9;
	localparam int CFG_DATA_W    = 13;
	localparam int CFG_INDEX_W   = 2;

	localparam int DEF_MAX_SOURCE_SIDE   = 4096;
	localparam int DEF_MAX_OUTPUT_WIDTH  = 512;
	localparam int DEF_MAX_OUTPUT_HEIGHT = 288;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SOURCE_WIDTH  = 2'd0,
		REG_SOURCE_HEIGHT = 2'd1,
		REG_OUTPUT_WIDTH  = 2'd2,
		REG_OUTPUT_HEIGHT = 2'd3
	} cfg_reg_t;

	// red in the lowest byte
	typedef struct packed {
		logic [PIX_W-1:0] alpha;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} rgba_t;

endpackage

`default_nettype wire

>>> rtl/nnds_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
// standalone; used by the downscaler core for step size and remainder
`timescale 1ns / 1ps
`default_nettype none

module nnds_divider #(
	parameter int NW = 13,
	parameter int DW = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               busy,
	output logic [NW-1:0]      quotient,
	output logic [DW-1:0]      remainder
);

	localparam int CNW = $clog2(NW + 1);

	logic [NW-1:0]  work_q;
	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  div_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic [DW:0]    trial;
	logic [DW:0]    diff;
	logic           ge;

	assign trial = {rem_q, work_q[NW-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	// reset holds the result of 1 / 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q <= NW'(1);
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			cnt_q  <= CNW'(NW);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			work_q <= {work_q[NW-2:0], ge};
			rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			cnt_q  <= cnt_q - CNW'(1);
			if (cnt_q == CNW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
		end
	end

	assign busy      = busy_q;
	assign quotient  = work_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

>>> rtl/nearest_neighbor_pixel_downscaler_core.sv
// nearest neighbor downscaler: picks source pixels of a raster stream
// depends on nnds_pkg and nnds_divider
//
// usage
//   s_* : source pixels in raster order, one transfer per pixel
//   m_* : selected pixels, m_tlast marks the last pixel of the scaled frame
//   cfg_*: register writes (0 source width, 1 source height,
//          2 output width, 3 output height), always ready
// timing
//   an input transfer reaches the output through the input register, then the
//   result register; one pixel per cycle sustained while m_tready is high
// configuration
//   each write restarts two bit-serial dividers (step = side / out, with
//   remainder); after the write edge s_tready stays low while the write is
//   pending and while either divider is busy
//   write registers only with no frame data in flight
// reset
//   all sizes read as 1, all counters and accumulators cleared
// backpressure
//   the result register and the input register each hold one pixel; while
//   m_tready is low a selected pixel waits and the input side takes one more
//   pixel, then s_tready drops; unselected pixels still drain while stalled
//   unless a selected one is stuck behind the result register
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbor_pixel_downscaler_core
	import nnds_pkg::*;
#(
	parameter int MAX_SOURCE_SIDE   = DEF_MAX_SOURCE_SIDE,
	parameter int MAX_OUTPUT_WIDTH  = DEF_MAX_OUTPUT_WIDTH,
	parameter int MAX_OUTPUT_HEIGHT = DEF_MAX_OUTPUT_HEIGHT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// source pixel stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [4*PIX_W-1:0]     s_tdata,   // red_in, green_in, blue_in, alpha_in
	// scaled pixel stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [4*PIX_W-1:0]          m_tdata,   // red_out, green_out, blue_out, alpha_out
	output logic                        m_tlast,   // frame_end
	// register write channel
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	// effective side widths (hold the maximum itself)
	localparam int SSW = $clog2(MAX_SOURCE_SIDE + 1);
	localparam int OWW = $clog2(MAX_OUTPUT_WIDTH + 1);
	localparam int OHW = $clog2(MAX_OUTPUT_HEIGHT + 1);
	// position counters (hold the maximum index)
	localparam int SCW = $clog2(MAX_SOURCE_SIDE);
	localparam int OCW = (MAX_OUTPUT_WIDTH > 1) ? $clog2(MAX_OUTPUT_WIDTH) : 1;
	localparam int ORW = (MAX_OUTPUT_HEIGHT > 1) ? $clog2(MAX_OUTPUT_HEIGHT) : 1;

	// ---------------- configuration registers ----------------
	logic [SRC_SIDE_W-1:0]   src_w_q, src_h_q;
	logic [OUT_WIDTH_W-1:0]  out_w_q;
	logic [OUT_HEIGHT_W-1:0] out_h_q;
	logic                    cfg_xfer;
	logic                    pend_q;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SRC_SIDE_W'(1);
			src_h_q <= SRC_SIDE_W'(1);
			out_w_q <= OUT_WIDTH_W'(1);
			out_h_q <= OUT_HEIGHT_W'(1);
			pend_q  <= 1'b0;
		end else begin
			pend_q <= cfg_xfer;
			if (cfg_xfer) begin
				case (cfg_reg_t'(cfg_index))
					REG_SOURCE_WIDTH:  src_w_q <= cfg_data[SRC_SIDE_W-1:0];
					REG_SOURCE_HEIGHT: src_h_q <= cfg_data[SRC_SIDE_W-1:0];
					REG_OUTPUT_WIDTH:  out_w_q <= cfg_data[OUT_WIDTH_W-1:0];
					REG_OUTPUT_HEIGHT: out_h_q <= cfg_data[OUT_HEIGHT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// ---------------- effective sizes ----------------
	// zero counts as one, then clamp to the maximum, output clamped to source
	logic [SSW-1:0] sw_c, sh_c;
	logic [OWW-1:0] owl_c, ow_c;
	logic [OHW-1:0] ohl_c, oh_c;

	always_comb begin
		if (src_w_q == '0)
			sw_c = SSW'(1);
		else if (32'(src_w_q) > 32'(MAX_SOURCE_SIDE))
			sw_c = SSW'(MAX_SOURCE_SIDE);
		else
			sw_c = SSW'(src_w_q);

		if (src_h_q == '0)
			sh_c = SSW'(1);
		else if (32'(src_h_q) > 32'(MAX_SOURCE_SIDE))
			sh_c = SSW'(MAX_SOURCE_SIDE);
		else
			sh_c = SSW'(src_h_q);

		if (out_w_q == '0)
			owl_c = OWW'(1);
		else if (32'(out_w_q) > 32'(MAX_OUTPUT_WIDTH))
			owl_c = OWW'(MAX_OUTPUT_WIDTH);
		else
			owl_c = OWW'(out_w_q);
		ow_c = (32'(owl_c) > 32'(sw_c)) ? OWW'(sw_c) : owl_c;

		if (out_h_q == '0)
			ohl_c = OHW'(1);
		else if (32'(out_h_q) > 32'(MAX_OUTPUT_HEIGHT))
			ohl_c = OHW'(MAX_OUTPUT_HEIGHT);
		else
			ohl_c = OHW'(out_h_q);
		oh_c = (32'(ohl_c) > 32'(sh_c)) ? OHW'(sh_c) : ohl_c;
	end

	logic [SSW-1:0] sw_q, sh_q;
	logic [OWW-1:0] ow_q;
	logic [OHW-1:0] oh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= SSW'(1);
			sh_q <= SSW'(1);
			ow_q <= OWW'(1);
			oh_q <= OHW'(1);
		end else begin
			sw_q <= sw_c;
			sh_q <= sh_c;
			ow_q <= ow_c;
			oh_q <= oh_c;
		end
	end

	// ---------------- step size dividers ----------------
	logic           col_busy, row_busy;
	logic [SSW-1:0] col_step, row_step;
	logic [OWW-1:0] col_frac;
	logic [OHW-1:0] row_frac;

	nnds_divider #(.NW(SSW), .DW(OWW)) u_col_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (pend_q),
		.dividend  (sw_c),
		.divisor   (ow_c),
		.busy      (col_busy),
		.quotient  (col_step),
		.remainder (col_frac)
	);

	nnds_divider #(.NW(SSW), .DW(OHW)) u_row_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (pend_q),
		.dividend  (sh_c),
		.divisor   (oh_c),
		.busy      (row_busy),
		.quotient  (row_step),
		.remainder (row_frac)
	);

	// ---------------- input register ----------------
	logic  valid_s1;
	rgba_t pix_s1;
	logic  out_free;
	logic  emit;
	logic  go_s1;
	logic  s_xfer;

	assign out_free = !m_tvalid || m_tready;
	// a pixel that is dropped never waits for the result register
	assign go_s1    = valid_s1 && (!emit || out_free);
	assign s_tready = !pend_q && !col_busy && !row_busy && (!valid_s1 || go_s1);
	assign s_xfer   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_xfer) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			pix_s1 <= rgba_t'(s_tdata);
		end
	end

	// ---------------- selection state ----------------
	logic [SCW-1:0] src_col_q, src_row_q;
	logic [OCW-1:0] out_col_q;
	logic [ORW-1:0] out_row_q;
	logic [SCW-1:0] col_tgt_q, row_tgt_q;
	logic [OWW-1:0] col_rem_q;
	logic [OHW-1:0] row_rem_q;

	logic           row_sel, row_end, frame_done, frame_end;
	logic [OWW:0]   col_acc;
	logic [OHW:0]   row_acc;
	logic           col_carry, row_carry;
	logic [SSW:0]   col_sum, row_sum;
	logic [OWW-1:0] col_rem_nxt;
	logic [OHW-1:0] row_rem_nxt;

	always_comb begin
		row_sel    = src_row_q == row_tgt_q;
		emit       = row_sel && (src_col_q == col_tgt_q);
		frame_end  = (OHW'(out_row_q) >= oh_q - OHW'(1))
			&& (OWW'(out_col_q) >= ow_q - OWW'(1));
		row_end    = SSW'(src_col_q) >= sw_q - SSW'(1);
		frame_done = SSW'(src_row_q) >= sh_q - SSW'(1);

		// target += side / outs, remainder += side % outs, carry on overflow
		col_acc     = {1'b0, col_rem_q} + {1'b0, col_frac};
		col_carry   = col_acc >= {1'b0, ow_q};
		col_rem_nxt = col_carry ? OWW'(col_acc - {1'b0, ow_q}) : col_acc[OWW-1:0];
		col_sum     = (SSW+1)'(col_tgt_q) + {1'b0, col_step} + (SSW+1)'(col_carry);

		row_acc     = {1'b0, row_rem_q} + {1'b0, row_frac};
		row_carry   = row_acc >= {1'b0, oh_q};
		row_rem_nxt = row_carry ? OHW'(row_acc - {1'b0, oh_q}) : row_acc[OHW-1:0];
		row_sum     = (SSW+1)'(row_tgt_q) + {1'b0, row_step} + (SSW+1)'(row_carry);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			col_tgt_q <= '0;
			row_tgt_q <= '0;
			col_rem_q <= '0;
			row_rem_q <= '0;
		end else if (go_s1) begin
			if (!row_end) begin
				src_col_q <= src_col_q + SCW'(1);
				if (emit) begin
					col_tgt_q <= col_sum[SCW-1:0];
					col_rem_q <= col_rem_nxt;
					if (OWW'(out_col_q) < ow_q - OWW'(1)) begin
						out_col_q <= out_col_q + OCW'(1);
					end
				end
			end else begin
				// end of source row: column side restarts
				src_col_q <= '0;
				out_col_q <= '0;
				col_tgt_q <= '0;
				col_rem_q <= '0;
				if (frame_done) begin
					src_row_q <= '0;
					out_row_q <= '0;
					row_tgt_q <= '0;
					row_rem_q <= '0;
				end else begin
					src_row_q <= src_row_q + SCW'(1);
					if (row_sel) begin
						row_tgt_q <= row_sum[SCW-1:0];
						row_rem_q <= row_rem_nxt;
						if (OHW'(out_row_q) < oh_q - OHW'(1)) begin
							out_row_q <= out_row_q + ORW'(1);
						end
					end
				end
			end
		end
	end

	// ---------------- result register ----------------
	logic  m_valid_q;
	rgba_t m_pix_q;
	logic  m_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (go_s1 && emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && emit) begin
			m_pix_q  <= pix_s1;
			m_last_q <= frame_end;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_pix_q;
	assign m_tlast  = m_last_q;

endmodule

`default_nettype wire

>>> rtl/nnds_checker.sv
// port-level checks for the downscaler core, bound to the core module
// depends on nnds_pkg and nearest_neighbor_pixel_downscaler_core_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_neighbor_pixel_downscaler_core_defines.svh"

module nnds_checker
	import nnds_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_tvalid,
	input wire logic               s_tready,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [4*PIX_W-1:0] m_tdata,
	input wire logic               m_tlast,
	input wire logic               cfg_valid,
	input wire logic               cfg_ready
);

	// a waiting result keeps its pixel and frame mark
	`NNDS_ASSERT_STALL_HOLD(a_out_hold, m_tvalid, m_tready, {m_tlast, m_tdata})

	// a register write blocks source pixels while step sizes are recomputed
	`NNDS_ASSERT_NEXT(a_cfg_blocks_input, cfg_valid && cfg_ready, !s_tready)

	// a result appearing on an empty output came from a source transfer through the input register
	`NNDS_ASSERT_NOW(a_out_from_input, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind nearest_neighbor_pixel_downscaler_core nnds_checker u_nnds_checker (.*);

`default_nettype wire
